### rtl/tlsc_pkg.sv
// shared types, constants and the sequencer programme of the calibration block
`timescale 1ns / 1ps

package tlsc_pkg;

  localparam int FW     = 12;   // input field width
  localparam int SUM_W  = 15;   // plain sum width
  localparam int SQ_W   = 27;   // product sum width
  localparam int CNT_W  = 3;    // point counter width
  localparam int K_W    = 64;   // cofactor and determinant width
  localparam int BW     = 28;   // serial multiplier operand width
  localparam int ACC_W  = 100;  // accumulator and dividend width
  localparam int COEF_W = 32;
  localparam int PC_W   = 6;
  localparam int SCALE_W = 17;
  localparam int FRAC_W = 16;

  typedef enum logic [2:0] {
    OP_MUL, OP_DIV, OP_PEND, OP_CHK, OP_OUT
  } op_e;

  typedef enum logic [3:0] {
    A_RX, A_RY, A_SX, A_SY, A_X, A_Y, A_X2, A_Y2, A_XY,
    A_KA, A_KB, A_KC, A_KE, A_KF, A_KI
  } asrc_e;

  typedef enum logic [3:0] {
    B_RX, B_RY, B_N, B_X, B_Y, B_X2, B_Y2, B_XY,
    B_SX, B_SXRX, B_SXRY, B_SY, B_SYRX, B_SYRY
  } bsrc_e;

  typedef enum logic [1:0] {
    I_ZERO, I_KEEP, I_DEST
  } init_e;

  typedef enum logic [4:0] {
    D_NONE, D_RXRX, D_RYRY, D_RXRY, D_SXRX, D_SXRY, D_SYRX, D_SYRY,
    D_KA, D_KB, D_KC, D_KE, D_KF, D_KI, D_DET,
    D_XO, D_XRX, D_XRY, D_YO, D_YRX, D_YRY, D_PAVG
  } dst_e;

  typedef struct packed {
    op_e   kind;
    asrc_e a_sel;
    bsrc_e b_sel;
    init_e init;
    logic  sub;
    dst_e  dest;
  } op_t;

  localparam logic [PC_W-1:0] PC_SOLVE = 6'd8;
  localparam logic [PC_W-1:0] PC_OUT   = 6'd49;

  function automatic op_t mk(op_e k, asrc_e a, bsrc_e b, init_e i, logic s, dst_e d);
    op_t o;
    o.kind  = k;
    o.a_sel = a;
    o.b_sel = b;
    o.init  = i;
    o.sub   = s;
    o.dest  = d;
    return o;
  endfunction

  // one coefficient: three products then the division
  function automatic op_t coef_op(logic [1:0] step, logic [1:0] col, logic ysel, dst_e d);
    asrc_e a;
    bsrc_e b;
    init_e i;
    a = A_KA;
    case (col)
      2'd0: begin
        case (step)
          2'd0: a = A_KA;
          2'd1: a = A_KB;
          default: a = A_KC;
        endcase
      end
      2'd1: begin
        case (step)
          2'd0: a = A_KB;
          2'd1: a = A_KE;
          default: a = A_KF;
        endcase
      end
      default: begin
        case (step)
          2'd0: a = A_KC;
          2'd1: a = A_KF;
          default: a = A_KI;
        endcase
      end
    endcase
    case (step)
      2'd0: b = ysel ? B_SY : B_SX;
      2'd1: b = ysel ? B_SYRX : B_SXRX;
      default: b = ysel ? B_SYRY : B_SXRY;
    endcase
    i = (step == 2'd0) ? I_ZERO : I_KEEP;
    if (step == 2'd3) return mk(OP_DIV, a, b, I_KEEP, 1'b0, d);
    return mk(OP_MUL, a, b, i, 1'b0, D_NONE);
  endfunction

  function automatic op_t op_rom(logic [PC_W-1:0] pc);
    logic [PC_W-1:0] rel;
    logic [2:0] grp;
    dst_e d;
    rel = pc - 6'd25;
    grp = rel[4:2];
    case (grp)
      3'd0: d = D_XO;
      3'd1: d = D_XRX;
      3'd2: d = D_XRY;
      3'd3: d = D_YO;
      3'd4: d = D_YRX;
      default: d = D_YRY;
    endcase
    case (pc)
      6'd0:  return mk(OP_MUL, A_RX, B_RX, I_DEST, 1'b0, D_RXRX);
      6'd1:  return mk(OP_MUL, A_RY, B_RY, I_DEST, 1'b0, D_RYRY);
      6'd2:  return mk(OP_MUL, A_RX, B_RY, I_DEST, 1'b0, D_RXRY);
      6'd3:  return mk(OP_MUL, A_SX, B_RX, I_DEST, 1'b0, D_SXRX);
      6'd4:  return mk(OP_MUL, A_SX, B_RY, I_DEST, 1'b0, D_SXRY);
      6'd5:  return mk(OP_MUL, A_SY, B_RX, I_DEST, 1'b0, D_SYRX);
      6'd6:  return mk(OP_MUL, A_SY, B_RY, I_DEST, 1'b0, D_SYRY);
      6'd7:  return mk(OP_PEND, A_RX, B_RX, I_ZERO, 1'b0, D_NONE);
      6'd8:  return mk(OP_MUL, A_X2, B_Y2, I_ZERO, 1'b0, D_NONE);
      6'd9:  return mk(OP_MUL, A_XY, B_XY, I_KEEP, 1'b1, D_KA);
      6'd10: return mk(OP_MUL, A_XY, B_Y,  I_ZERO, 1'b0, D_NONE);
      6'd11: return mk(OP_MUL, A_X,  B_Y2, I_KEEP, 1'b1, D_KB);
      6'd12: return mk(OP_MUL, A_X,  B_XY, I_ZERO, 1'b0, D_NONE);
      6'd13: return mk(OP_MUL, A_Y,  B_X2, I_KEEP, 1'b1, D_KC);
      6'd14: return mk(OP_MUL, A_Y2, B_N,  I_ZERO, 1'b0, D_NONE);
      6'd15: return mk(OP_MUL, A_Y,  B_Y,  I_KEEP, 1'b1, D_KE);
      6'd16: return mk(OP_MUL, A_X,  B_Y,  I_ZERO, 1'b0, D_NONE);
      6'd17: return mk(OP_MUL, A_XY, B_N,  I_KEEP, 1'b1, D_KF);
      6'd18: return mk(OP_MUL, A_X2, B_N,  I_ZERO, 1'b0, D_NONE);
      6'd19: return mk(OP_MUL, A_X,  B_X,  I_KEEP, 1'b1, D_KI);
      6'd20: return mk(OP_MUL, A_KA, B_N,  I_ZERO, 1'b0, D_NONE);
      6'd21: return mk(OP_MUL, A_KB, B_X,  I_KEEP, 1'b0, D_NONE);
      6'd22: return mk(OP_MUL, A_KC, B_Y,  I_KEEP, 1'b0, D_DET);
      6'd23: return mk(OP_DIV, A_RX, B_RX, I_ZERO, 1'b0, D_PAVG);
      6'd24: return mk(OP_CHK, A_RX, B_RX, I_ZERO, 1'b0, D_NONE);
      PC_OUT: return mk(OP_OUT, A_RX, B_RX, I_ZERO, 1'b0, D_NONE);
      default: begin
        if (pc > 6'd24 && pc < PC_OUT)
          return coef_op(rel[1:0], (grp > 3'd2) ? 2'(grp - 3'd3) : grp[1:0],
                         grp > 3'd2, d);
        return mk(OP_OUT, A_RX, B_RX, I_ZERO, 1'b0, D_NONE);
      end
    endcase
  endfunction

endpackage

### rtl/tlsc_serial_mul.sv
// bit-serial shift-add multiplier, signed multiplicand times unsigned multiplier
`timescale 1ns / 1ps

module tlsc_serial_mul import tlsc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    sub_i,
  input  logic signed [K_W-1:0]   a_i,
  input  logic        [BW-1:0]    b_i,
  input  logic signed [ACC_W-1:0] init_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [ACC_W-1:0] acc_q, a_q;
  logic        [BW-1:0]    b_q;
  logic                    run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      a_q   <= '0;
      b_q   <= '0;
      run_q <= 1'b0;
    end else if (start_i) begin
      acc_q <= init_i;
      a_q   <= {{(ACC_W-K_W){a_i[K_W-1]}}, a_i};
      b_q   <= b_i;
      run_q <= 1'b1;
    end else if (run_q) begin
      if (b_q == '0) begin
        run_q <= 1'b0;
      end else begin
        // one multiplier bit per cycle
        if (b_q[0]) acc_q <= sub_i ? acc_q - a_q : acc_q + a_q;
        a_q <= a_q <<< 1;
        b_q <= b_q >> 1;
      end
    end
  end

  assign busy_o = run_q;
  assign done_o = run_q && (b_q == '0);
  assign acc_o  = acc_q;

endmodule

### rtl/tlsc_serial_div.sv
// restoring divider, one quotient bit per cycle, scaled by 2^16 and saturated
`timescale 1ns / 1ps

module tlsc_serial_div import tlsc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic signed [ACC_W-1:0]  num_i,
  input  logic signed [K_W-1:0]    den_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic        [COEF_W-1:0] quo_o
);

  localparam int CW = $clog2(ACC_W);

  logic [ACC_W-1:0] sh_q;
  logic [K_W-1:0]   rem_q, d_q;
  logic             neg_q, run_q, done_q;
  logic [CW-1:0]    cnt_q;

  logic [ACC_W-1:0] mag;
  logic [K_W:0]     trial;
  logic             fits;

  assign mag   = num_i[ACC_W-1] ? ACC_W'(-num_i) : ACC_W'(num_i);
  assign trial = {rem_q, sh_q[ACC_W-1]};
  assign fits  = trial >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q   <= '0;
      rem_q  <= '0;
      d_q    <= '0;
      neg_q  <= 1'b0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        sh_q  <= mag << FRAC_W;
        rem_q <= '0;
        d_q   <= den_i[K_W-1] ? K_W'(-den_i) : K_W'(den_i);
        neg_q <= num_i[ACC_W-1] ^ den_i[K_W-1];
        cnt_q <= CW'(ACC_W - 1);
        run_q <= 1'b1;
      end else if (run_q) begin
        rem_q <= fits ? K_W'(trial - {1'b0, d_q}) : trial[K_W-1:0];
        sh_q  <= {sh_q[ACC_W-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // saturate the magnitude to the signed 32-bit range, then apply the sign
  logic [COEF_W:0]   limit;
  logic              over;
  logic [COEF_W-1:0] sat;

  always_comb begin
    limit = neg_q ? {1'b0, 1'b1, {(COEF_W-1){1'b0}}} : {2'b00, {(COEF_W-1){1'b1}}};
    over  = (|sh_q[ACC_W-1:COEF_W]) || ({1'b0, sh_q[COEF_W-1:0]} > limit);
    sat   = over ? limit[COEF_W-1:0] : sh_q[COEF_W-1:0];
    quo_o = neg_q ? COEF_W'(-sat) : sat;
  end

  assign busy_o = run_q;
  assign done_o = done_q;

endmodule

### rtl/touch_least_squares_calibration.sv
// top level of the least-squares touch calibration block
`timescale 1ns / 1ps

// touch_least_squares_calibration
// a transaction on the input side is one calibration point: raw touch x/y, the
// screen x/y it should map to and a pressure sample, taken when start_i is high
// and busy_o is low. after every SAMPLES points the block solves the 3x3 normal
// equations of the affine fit and pulses done_o for one cycle with the six
// coefficients (times 65536, saturated), ok_o, scale_o and the mean pressure.
// the receiver cannot stall: done_o marks the result for exactly that one cycle.
// the multiplier works one significant multiplier bit at a time and the divider
// one quotient bit at a time. a point runs seven products and one last-point
// test, and a new point is taken only once busy_o is low again. the last point
// adds 15 cofactor products, the pressure division, the determinant check, 18
// products and six divisions. done_o pulses in the first cycle busy_o is low.
// a zero determinant skips the coefficient work and reports ok_o low with zero
// coefficients. after the result the sums clear.
// reset clears all sums and the point count; no result is pending after it.

module touch_least_squares_calibration import tlsc_pkg::*; #(
  parameter int SAMPLES = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [FW-1:0]            raw_x_i,
  input  logic [FW-1:0]            raw_y_i,
  input  logic [FW-1:0]            screen_x_i,
  input  logic [FW-1:0]            screen_y_i,
  input  logic [FW-1:0]            pressure_i,
  output logic                     done_o,
  output logic                     ok_o,
  output logic signed [COEF_W-1:0] x_offset_o,
  output logic signed [COEF_W-1:0] x_from_raw_x_o,
  output logic signed [COEF_W-1:0] x_from_raw_y_o,
  output logic signed [COEF_W-1:0] y_offset_o,
  output logic signed [COEF_W-1:0] y_from_raw_x_o,
  output logic signed [COEF_W-1:0] y_from_raw_y_o,
  output logic [SCALE_W-1:0]       scale_o,
  output logic [FW-1:0]            pressure_average_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT} state_e;

  state_e state_q;
  logic [PC_W-1:0]  pc_q;
  logic [CNT_W-1:0] cnt_q;
  logic             last_q;

  // latched point
  logic [FW-1:0] rx_q, ry_q, sx_q, sy_q;

  // running sums
  logic [SUM_W-1:0] s_rx_q, s_ry_q, s_sx_q, s_sy_q, s_pr_q;
  logic [SQ_W-1:0]  s_rxrx_q, s_ryry_q, s_rxry_q;
  logic [SQ_W-1:0]  s_sxrx_q, s_sxry_q, s_syrx_q, s_syry_q;

  // adjugate entries and determinant
  logic signed [K_W-1:0] ka_q, kb_q, kc_q, ke_q, kf_q, ki_q, det_q;

  // result registers
  logic                     done_q, ok_q;
  logic signed [COEF_W-1:0] xo_q, xrx_q, xry_q, yo_q, yrx_q, yry_q;
  logic [FW-1:0]            pavg_q;

  op_t op;
  assign op = op_rom(pc_q);

  logic accept;
  assign accept = start_i && !busy_o;

  logic [CNT_W-1:0] cnt_inc;
  assign cnt_inc = cnt_q + 1'b1;

  // operand selection
  logic signed [K_W-1:0]   a_val;
  logic        [BW-1:0]    b_val;
  logic        [SQ_W-1:0]  dest_val;
  logic signed [ACC_W-1:0] mul_init;

  always_comb begin
    case (op.a_sel)
      A_RX:    a_val = K_W'(rx_q);
      A_RY:    a_val = K_W'(ry_q);
      A_SX:    a_val = K_W'(sx_q);
      A_SY:    a_val = K_W'(sy_q);
      A_X:     a_val = K_W'(s_rx_q);
      A_Y:     a_val = K_W'(s_ry_q);
      A_X2:    a_val = K_W'(s_rxrx_q);
      A_Y2:    a_val = K_W'(s_ryry_q);
      A_XY:    a_val = K_W'(s_rxry_q);
      A_KA:    a_val = ka_q;
      A_KB:    a_val = kb_q;
      A_KC:    a_val = kc_q;
      A_KE:    a_val = ke_q;
      A_KF:    a_val = kf_q;
      A_KI:    a_val = ki_q;
      default: a_val = '0;
    endcase
    case (op.b_sel)
      B_RX:    b_val = BW'(rx_q);
      B_RY:    b_val = BW'(ry_q);
      B_N:     b_val = BW'(SAMPLES);
      B_X:     b_val = BW'(s_rx_q);
      B_Y:     b_val = BW'(s_ry_q);
      B_X2:    b_val = BW'(s_rxrx_q);
      B_Y2:    b_val = BW'(s_ryry_q);
      B_XY:    b_val = BW'(s_rxry_q);
      B_SX:    b_val = BW'(s_sx_q);
      B_SXRX:  b_val = BW'(s_sxrx_q);
      B_SXRY:  b_val = BW'(s_sxry_q);
      B_SY:    b_val = BW'(s_sy_q);
      B_SYRX:  b_val = BW'(s_syrx_q);
      B_SYRY:  b_val = BW'(s_syry_q);
      default: b_val = '0;
    endcase
    case (op.dest)
      D_RXRX:  dest_val = s_rxrx_q;
      D_RYRY:  dest_val = s_ryry_q;
      D_RXRY:  dest_val = s_rxry_q;
      D_SXRX:  dest_val = s_sxrx_q;
      D_SXRY:  dest_val = s_sxry_q;
      D_SYRX:  dest_val = s_syrx_q;
      D_SYRY:  dest_val = s_syry_q;
      default: dest_val = '0;
    endcase
  end

  // shared arithmetic units
  logic                    mul_start, mul_busy, mul_done;
  logic signed [ACC_W-1:0] mul_acc;
  logic                    div_start, div_busy, div_done;
  logic signed [ACC_W-1:0] div_num;
  logic signed [K_W-1:0]   div_den;
  logic [COEF_W-1:0]       div_quo;

  always_comb begin
    case (op.init)
      I_KEEP:  mul_init = mul_acc;
      I_DEST:  mul_init = ACC_W'(dest_val);
      default: mul_init = '0;
    endcase
  end

  assign mul_start = (state_q == ST_ISSUE) && (op.kind == OP_MUL);
  assign div_start = (state_q == ST_ISSUE) && (op.kind == OP_DIV);
  // pressure mean goes through the divider as (sum * 65536) / SAMPLES
  assign div_num   = (op.dest == D_PAVG) ? ACC_W'(s_pr_q) : mul_acc;
  assign div_den   = (op.dest == D_PAVG) ? K_W'(SAMPLES) : det_q;

  tlsc_serial_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .sub_i   (op.sub),
    .a_i     (a_val),
    .b_i     (b_val),
    .init_i  (mul_init),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .acc_o   (mul_acc)
  );

  tlsc_serial_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  logic unit_done;
  assign unit_done = (op.kind == OP_MUL) ? mul_done : div_done;

  // sequencer, sums and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      pc_q     <= '0;
      cnt_q    <= '0;
      last_q   <= 1'b0;
      rx_q     <= '0;
      ry_q     <= '0;
      sx_q     <= '0;
      sy_q     <= '0;
      s_rx_q   <= '0;
      s_ry_q   <= '0;
      s_sx_q   <= '0;
      s_sy_q   <= '0;
      s_pr_q   <= '0;
      s_rxrx_q <= '0;
      s_ryry_q <= '0;
      s_rxry_q <= '0;
      s_sxrx_q <= '0;
      s_sxry_q <= '0;
      s_syrx_q <= '0;
      s_syry_q <= '0;
      ka_q     <= '0;
      kb_q     <= '0;
      kc_q     <= '0;
      ke_q     <= '0;
      kf_q     <= '0;
      ki_q     <= '0;
      det_q    <= '0;
      done_q   <= 1'b0;
      ok_q     <= 1'b0;
      xo_q     <= '0;
      xrx_q    <= '0;
      xry_q    <= '0;
      yo_q     <= '0;
      yrx_q    <= '0;
      yry_q    <= '0;
      pavg_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            rx_q    <= raw_x_i;
            ry_q    <= raw_y_i;
            sx_q    <= screen_x_i;
            sy_q    <= screen_y_i;
            s_rx_q  <= s_rx_q + SUM_W'(raw_x_i);
            s_ry_q  <= s_ry_q + SUM_W'(raw_y_i);
            s_sx_q  <= s_sx_q + SUM_W'(screen_x_i);
            s_sy_q  <= s_sy_q + SUM_W'(screen_y_i);
            s_pr_q  <= s_pr_q + SUM_W'(pressure_i);
            cnt_q   <= cnt_inc;
            last_q  <= (cnt_inc == CNT_W'(SAMPLES));
            pc_q    <= '0;
            state_q <= ST_ISSUE;
          end
        end
        ST_ISSUE: begin
          case (op.kind)
            OP_MUL, OP_DIV: state_q <= ST_WAIT;
            OP_PEND: begin
              // only the last point of a set goes on to the solve
              if (last_q) pc_q <= PC_SOLVE;
              else state_q <= ST_IDLE;
            end
            OP_CHK: begin
              ok_q <= (det_q != '0);
              if (det_q == '0) begin
                xo_q  <= '0;
                xrx_q <= '0;
                xry_q <= '0;
                yo_q  <= '0;
                yrx_q <= '0;
                yry_q <= '0;
                pc_q  <= PC_OUT;
              end else begin
                pc_q <= pc_q + 1'b1;
              end
            end
            default: begin
              // result strobe and clear for the next set
              done_q   <= 1'b1;
              cnt_q    <= '0;
              last_q   <= 1'b0;
              s_rx_q   <= '0;
              s_ry_q   <= '0;
              s_sx_q   <= '0;
              s_sy_q   <= '0;
              s_pr_q   <= '0;
              s_rxrx_q <= '0;
              s_ryry_q <= '0;
              s_rxry_q <= '0;
              s_sxrx_q <= '0;
              s_sxry_q <= '0;
              s_syrx_q <= '0;
              s_syry_q <= '0;
              state_q  <= ST_IDLE;
            end
          endcase
        end
        ST_WAIT: begin
          if (unit_done) begin
            case (op.dest)
              D_RXRX: s_rxrx_q <= mul_acc[SQ_W-1:0];
              D_RYRY: s_ryry_q <= mul_acc[SQ_W-1:0];
              D_RXRY: s_rxry_q <= mul_acc[SQ_W-1:0];
              D_SXRX: s_sxrx_q <= mul_acc[SQ_W-1:0];
              D_SXRY: s_sxry_q <= mul_acc[SQ_W-1:0];
              D_SYRX: s_syrx_q <= mul_acc[SQ_W-1:0];
              D_SYRY: s_syry_q <= mul_acc[SQ_W-1:0];
              D_KA:   ka_q     <= mul_acc[K_W-1:0];
              D_KB:   kb_q     <= mul_acc[K_W-1:0];
              D_KC:   kc_q     <= mul_acc[K_W-1:0];
              D_KE:   ke_q     <= mul_acc[K_W-1:0];
              D_KF:   kf_q     <= mul_acc[K_W-1:0];
              D_KI:   ki_q     <= mul_acc[K_W-1:0];
              D_DET:  det_q    <= mul_acc[K_W-1:0];
              D_XO:   xo_q     <= div_quo;
              D_XRX:  xrx_q    <= div_quo;
              D_XRY:  xry_q    <= div_quo;
              D_YO:   yo_q     <= div_quo;
              D_YRX:  yrx_q    <= div_quo;
              D_YRY:  yry_q    <= div_quo;
              D_PAVG: pavg_q   <= div_quo[FRAC_W+FW-1:FRAC_W];
              default: ;
            endcase
            pc_q    <= pc_q + 1'b1;
            state_q <= ST_ISSUE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o             = (state_q != ST_IDLE);
  assign done_o             = done_q;
  assign ok_o               = ok_q;
  assign x_offset_o         = xo_q;
  assign x_from_raw_x_o     = xrx_q;
  assign x_from_raw_y_o     = xry_q;
  assign y_offset_o         = yo_q;
  assign y_from_raw_x_o     = yrx_q;
  assign y_from_raw_y_o     = yry_q;
  assign scale_o            = SCALE_W'(1) << FRAC_W;
  assign pressure_average_o = pavg_q;

  // the two arithmetic units never run together
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mul_busy && div_busy))
    else $error("multiplier and divider active together");

  // a result leaves the counter and sums cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (cnt_q == '0) && (s_pr_q == '0))
    else $error("sums not cleared after result");

  // an accepted point keeps the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy_o)
    else $error("point accepted without going busy");

  // the multiplier is only started from the issue state while both units are idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy && !div_busy)
    else $error("multiplier started while a unit is busy");

endmodule

### tb/tb.sv
// self-checking testbench for the least-squares touch calibration block
`timescale 1ns / 1ps

module tb;
  import tlsc_pkg::*;

  localparam int          NPTS       = 5;
  localparam int          RAND_SETS  = 86;
  localparam int          MAX_ERRS   = 10;
  localparam longint      CYCLE_CAP  = 2000000;
  localparam int          DRAIN_WAIT = 1500;
  localparam logic [16:0] UNIT_SCALE = 17'd65536;

  // what one solved calibration set should produce
  typedef struct {
    logic                     ok;
    logic signed [COEF_W-1:0] coef [6];
    logic [SCALE_W-1:0]       scale;
    logic [FW-1:0]            pavg;
  } calib_t;

  // one directed calibration point; typed rows carry a hand-written result
  typedef struct {
    logic [FW-1:0] rx, ry, sx, sy, pr;
    bit            typed;
    logic [FW-1:0] typed_pavg;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [FW-1:0] raw_x_i = '0, raw_y_i = '0, screen_x_i = '0, screen_y_i = '0;
  logic [FW-1:0] pressure_i = '0;
  logic busy_o, done_o, ok_o;
  logic signed [COEF_W-1:0] x_offset_o, x_from_raw_x_o, x_from_raw_y_o;
  logic signed [COEF_W-1:0] y_offset_o, y_from_raw_x_o, y_from_raw_y_o;
  logic [SCALE_W-1:0] scale_o;
  logic [FW-1:0] pressure_average_o;

  calib_t pending_fits[$];
  int     mismatches = 0;
  longint cycles = 0;

  // running least-squares sums of the fit in progress
  int     pts_seen = 0;
  longint s_rx, s_ry, s_rxx, s_ryy, s_rxy, s_sx, s_sxrx, s_sxry, s_sy, s_syrx, s_syry;
  longint s_pr;

  touch_least_squares_calibration #(.SAMPLES(NPTS)) u_top (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // sum . cofactor row, scaled by 2^16, divided with truncation, then clamped
  function automatic logic signed [COEF_W-1:0] fit_coef(longint k0, longint k1, longint k2,
      longint z, longint zx, longint zy, longint det);
    logic signed [127:0] num, quo;
    num = ((128'(k0) * 128'(z)) + (128'(k1) * 128'(zx)) + (128'(k2) * 128'(zy))) <<< 16;
    quo = num / 128'(det);
    if (quo > 128'sd2147483647)  return 32'sh7fffffff;
    if (quo < -128'sd2147483648) return 32'sh80000000;
    return quo[31:0];
  endfunction

  function automatic calib_t solve_fit();
    calib_t r;
    longint n, ka, kb, kc, ke, kf, ki, det;
    n   = NPTS;
    ka  = s_rxx * s_ryy - s_rxy * s_rxy;
    kb  = s_rxy * s_ry - s_rx * s_ryy;
    kc  = s_rx * s_rxy - s_ry * s_rxx;
    ke  = n * s_ryy - s_ry * s_ry;
    kf  = s_rx * s_ry - n * s_rxy;
    ki  = n * s_rxx - s_rx * s_rx;
    det = n * ka + s_rx * kb + s_ry * kc;
    foreach (r.coef[i]) r.coef[i] = '0;
    r.ok = (det != 0);
    if (r.ok) begin
      r.coef[0] = fit_coef(ka, kb, kc, s_sx, s_sxrx, s_sxry, det);
      r.coef[1] = fit_coef(kb, ke, kf, s_sx, s_sxrx, s_sxry, det);
      r.coef[2] = fit_coef(kc, kf, ki, s_sx, s_sxrx, s_sxry, det);
      r.coef[3] = fit_coef(ka, kb, kc, s_sy, s_syrx, s_syry, det);
      r.coef[4] = fit_coef(kb, ke, kf, s_sy, s_syrx, s_syry, det);
      r.coef[5] = fit_coef(kc, kf, ki, s_sy, s_syrx, s_syry, det);
    end
    r.scale = UNIT_SCALE;
    r.pavg  = FW'(s_pr / NPTS);
    return r;
  endfunction

  function automatic void clear_sums();
    pts_seen = 0;
    {s_rx, s_ry, s_rxx, s_ryy, s_rxy, s_sx, s_sxrx, s_sxry} = '0;
    {s_sy, s_syrx, s_syry, s_pr} = '0;
  endfunction

  // fold an accepted point into the sums; the last of a set yields a fit
  function automatic void add_point(point_t p);
    calib_t r;
    s_rx += p.rx;  s_ry += p.ry;
    s_rxx += p.rx * p.rx;  s_ryy += p.ry * p.ry;  s_rxy += p.rx * p.ry;
    s_sx += p.sx;  s_sxrx += p.sx * p.rx;  s_sxry += p.sx * p.ry;
    s_sy += p.sy;  s_syrx += p.sy * p.rx;  s_syry += p.sy * p.ry;
    s_pr += p.pr;
    pts_seen++;
    if (pts_seen == NPTS) begin
      r = solve_fit();
      if (p.typed) begin
        // degenerate set: no solution, coefficients forced to zero
        r.ok = 1'b0;
        foreach (r.coef[i]) r.coef[i] = '0;
        r.scale = UNIT_SCALE;
        r.pavg  = p.typed_pavg;
      end
      pending_fits.push_back(r);
      clear_sums();
    end
  endfunction

  // drive one point at the falling edge and hold it until the block takes it
  task automatic send_point(point_t p);
    @(negedge clk_i);
    start_i    <= 1'b1;
    raw_x_i    <= p.rx;
    raw_y_i    <= p.ry;
    screen_x_i <= p.sx;
    screen_y_i <= p.sy;
    pressure_i <= p.pr;
    do @(posedge clk_i); while (busy_o);
    add_point(p);
    @(negedge clk_i);
    start_i <= 1'b0;
  endtask

  // mostly back-to-back or short gaps, now and then a long one
  task automatic idle_gap();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: n = 0;
      9:          n = $urandom_range(50, 400);
      default:    n = $urandom_range(1, 5);
    endcase
    repeat (n) @(negedge clk_i);
  endtask

  function automatic point_t mk_point(int rx, int ry, int sx, int sy, int pr);
    point_t p;
    p.rx = FW'(rx); p.ry = FW'(ry); p.sx = FW'(sx); p.sy = FW'(sy); p.pr = FW'(pr);
    p.typed = 0; p.typed_pavg = '0;
    return p;
  endfunction

  // result side: every done_o pulse is one transaction, checked against the oldest fit
  always @(posedge clk_i) begin
    calib_t want;
    logic signed [COEF_W-1:0] got [6];
    bit bad;
    if (rst_ni && done_o) begin
      got = '{x_offset_o, x_from_raw_x_o, x_from_raw_y_o,
              y_offset_o, y_from_raw_x_o, y_from_raw_y_o};
      if (pending_fits.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_ERRS) $display("unexpected result transaction at %0t", $time);
      end else begin
        want = pending_fits.pop_front();
        bad  = (ok_o !== want.ok) || (scale_o !== want.scale)
            || (pressure_average_o !== want.pavg);
        foreach (got[i]) if (got[i] !== want.coef[i]) bad = 1;
        if (bad) begin
          mismatches++;
          if (mismatches <= MAX_ERRS)
            $display({"mismatch at %0t: exp ok=%0b c=%p scale=%0d pavg=%0d, ",
                      "got ok=%0b c=%p scale=%0d pavg=%0d"},
                     $time, want.ok, want.coef, want.scale, want.pavg,
                     ok_o, got, scale_o, pressure_average_o);
        end
      end
    end
  end

  // watchdog on total run length
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    point_t dir_pts[$];
    point_t p;
    int kind, base, wait_cnt;

    clear_sums();
    // all-zero set: collinear, no solution, zero mean pressure
    repeat (NPTS) dir_pts.push_back(mk_point(0, 0, 0, 0, 0));
    dir_pts[NPTS-1].typed = 1;
    // all at full scale: also degenerate, mean pressure at its top
    repeat (NPTS) dir_pts.push_back(mk_point(4095, 4095, 4095, 4095, 4095));
    dir_pts[2*NPTS-1].typed = 1;
    dir_pts[2*NPTS-1].typed_pavg = 12'd4095;
    // well-conditioned corners and centre, identity-like mapping
    dir_pts.push_back(mk_point(0, 0, 0, 0, 1));
    dir_pts.push_back(mk_point(4095, 0, 4095, 0, 2048));
    dir_pts.push_back(mk_point(0, 4095, 0, 4095, 4095));
    dir_pts.push_back(mk_point(4095, 4095, 4095, 4095, 7));
    dir_pts.push_back(mk_point(2048, 2048, 2048, 2048, 100));
    // nearly collinear raw points, huge gains, clamping expected
    dir_pts.push_back(mk_point(0, 0, 4095, 0, 0));
    dir_pts.push_back(mk_point(1, 1, 0, 4095, 0));
    dir_pts.push_back(mk_point(2, 2, 4095, 0, 0));
    dir_pts.push_back(mk_point(3, 3, 0, 4095, 0));
    dir_pts.push_back(mk_point(4095, 4094, 4095, 4095, 0));
    // raw points on a diagonal line: zero determinant, inverted screen map
    for (int i = 0; i < NPTS; i++)
      dir_pts.push_back(mk_point(i * 1000, i * 1000, 4095 - i * 1000, i * 7, 4095 - i));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_pts[i]) begin
      send_point(dir_pts[i]);
      idle_gap();
    end

    for (int set_i = 0; set_i < RAND_SETS; set_i++) begin
      kind = $urandom_range(0, 9);
      base = $urandom_range(0, 4000);
      // let the block drain completely once partway through
      if (set_i == RAND_SETS / 2) wait (pending_fits.size() == 0);
      for (int k = 0; k < NPTS; k++) begin
        p = mk_point($urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom_range(0, 4095));
        case (kind)
          0: p.ry = p.rx;                                  // collinear on a diagonal
          1: p.rx = FW'(base);                             // constant raw x
          2: begin                                         // tight cluster, steep gains
            p.rx = FW'(base + $urandom_range(0, 3));
            p.ry = FW'(base + $urandom_range(0, 3));
          end
          default: ;
        endcase
        send_point(p);
        idle_gap();
      end
    end

    wait_cnt = 0;
    while (pending_fits.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0 && pending_fits.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
